// ===== sv/ucfg_pkg.sv =====
`timescale 1ns / 1ps
// Package for the USB configuration endpoint selector.
// Holds field widths, descriptor type codes and the endpoint address mask.
package ucfg_pkg;

    localparam int BYTE_W = 8;
    localparam int EP_W   = 7;

    localparam logic [BYTE_W-1:0] TYPE_INTERFACE = 8'd4;
    localparam logic [BYTE_W-1:0] TYPE_ENDPOINT  = 8'd5;
    localparam logic [BYTE_W-1:0] EP_ADDR_MASK   = 8'h7F;

    localparam logic [BYTE_W-1:0] OFS_LENGTH    = 8'd0;
    localparam logic [BYTE_W-1:0] OFS_TYPE      = 8'd1;
    localparam logic [BYTE_W-1:0] OFS_INTERFACE = 8'd2;
    localparam logic [BYTE_W-1:0] OFS_ALTERNATE = 8'd3;
    localparam logic [BYTE_W-1:0] OFS_PROTOCOL  = 8'd7;
    localparam logic [BYTE_W-1:0] OFS_EP_ADDR   = 8'd2;

    localparam logic [EP_W-1:0] EP_NONE = 7'd1;

endpackage

// ===== sv/ucfg_if.sv =====
`timescale 1ns / 1ps
// Request channels of the USB configuration endpoint selector.
// Depends on ucfg_pkg for the field widths.
interface ucfg_in_if;
    logic                        valid;
    logic                        ready;
    logic [ucfg_pkg::BYTE_W-1:0] data_byte;
    logic                        last_byte;

    modport source(output valid, output data_byte, output last_byte, input ready);
    modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface ucfg_out_if;
    logic                        valid;
    logic                        ready;
    logic [ucfg_pkg::BYTE_W-1:0] sel_interface;
    logic [ucfg_pkg::BYTE_W-1:0] sel_alternate;
    logic [ucfg_pkg::EP_W-1:0]   sel_endpoint;
    logic                        malformed;

    modport source(output valid, output sel_interface, output sel_alternate,
                   output sel_endpoint, output malformed, input ready);
    modport sink(input valid, input sel_interface, input sel_alternate,
                 input sel_endpoint, input malformed, output ready);
endinterface

// ===== sv/usb_config_endpoint_selector_unit.sv =====
`timescale 1ns / 1ps
// USB configuration endpoint selector: one descriptor byte per request.
// A last byte is parsed from the input register into the output register.
// Throughput: one request per cycle, set by the input register feeding the
// combinational parse step; a held result stalls only a following last byte.
// Reset (synchronous, active low) clears the parse state and both stages.
// Depends on ucfg_pkg and the channel interfaces in ucfg_if.
module usb_config_endpoint_selector_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ucfg_in_if.sink    i_req,
    ucfg_out_if.source o_res
);
    import ucfg_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    logic [BYTE_W-1:0] r_byte_offset, n_byte_offset;
    logic [BYTE_W-1:0] r_desc_length, n_desc_length;
    logic [BYTE_W-1:0] r_desc_type, n_desc_type;
    logic [BYTE_W-1:0] r_cur_interface, n_cur_interface;
    logic [BYTE_W-1:0] r_cur_alternate, n_cur_alternate;
    logic [BYTE_W-1:0] r_cur_protocol, n_cur_protocol;
    logic [BYTE_W-1:0] r_best_protocol, n_best_protocol;
    logic [BYTE_W-1:0] r_best_iface, n_best_iface;
    logic [BYTE_W-1:0] r_best_alt, n_best_alt;
    logic [EP_W-1:0]   r_best_ep, n_best_ep;
    logic              r_bad, n_bad;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_iface;
    logic [BYTE_W-1:0] r_out_alt;
    logic [EP_W-1:0]   r_out_ep;
    logic              r_out_bad;

    logic              advance;
    logic              finish;
    logic [BYTE_W-1:0] next_ofs;

    assign advance     = r_in_valid && (!r_in_last || !r_out_valid || o_res.ready);
    assign finish      = advance && r_in_last;
    assign i_req.ready = !r_in_valid || advance;

    always_comb begin
        n_byte_offset   = r_byte_offset;
        n_desc_length   = r_desc_length;
        n_desc_type     = r_desc_type;
        n_cur_interface = r_cur_interface;
        n_cur_alternate = r_cur_alternate;
        n_cur_protocol  = r_cur_protocol;
        n_best_protocol = r_best_protocol;
        n_best_iface    = r_best_iface;
        n_best_alt      = r_best_alt;
        n_best_ep       = r_best_ep;
        n_bad           = r_bad;
        next_ofs        = r_byte_offset + 8'd1;
        if (!r_bad) begin
            if (r_byte_offset == OFS_LENGTH) begin
                n_desc_length = r_in_byte;
            end else if (r_byte_offset == OFS_TYPE) begin
                n_desc_type = r_in_byte;
            end else if (r_desc_type == TYPE_INTERFACE) begin
                if (r_byte_offset == OFS_INTERFACE) begin
                    n_cur_interface = r_in_byte;
                end else if (r_byte_offset == OFS_ALTERNATE) begin
                    n_cur_alternate = r_in_byte;
                end else if (r_byte_offset == OFS_PROTOCOL) begin
                    n_cur_protocol = r_in_byte;
                end
            end else if (r_desc_type == TYPE_ENDPOINT && r_byte_offset == OFS_EP_ADDR) begin
                if (r_cur_protocol >= r_best_protocol) begin
                    n_best_protocol = r_cur_protocol;
                    n_best_iface    = r_cur_interface;
                    n_best_alt      = r_cur_alternate;
                    n_best_ep       = EP_W'(r_in_byte & EP_ADDR_MASK);
                end
            end
            // A zero length byte stops parsing until the end of the set.
            if (r_byte_offset == OFS_LENGTH && r_in_byte == '0) begin
                n_bad = 1'b1;
            end else begin
                n_byte_offset = (next_ofs == n_desc_length) ? '0 : next_ofs;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_byte_offset   <= '0;
            r_desc_length   <= '0;
            r_desc_type     <= '0;
            r_cur_interface <= '0;
            r_cur_alternate <= '0;
            r_cur_protocol  <= '0;
            r_best_protocol <= '0;
            r_best_iface    <= '0;
            r_best_alt      <= '0;
            r_best_ep       <= EP_NONE;
            r_bad           <= 1'b0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (finish) begin
                r_byte_offset   <= '0;
                r_desc_length   <= '0;
                r_desc_type     <= '0;
                r_cur_interface <= '0;
                r_cur_alternate <= '0;
                r_cur_protocol  <= '0;
                r_best_protocol <= '0;
                r_best_iface    <= '0;
                r_best_alt      <= '0;
                r_best_ep       <= EP_NONE;
                r_bad           <= 1'b0;
            end else if (advance) begin
                r_byte_offset   <= n_byte_offset;
                r_desc_length   <= n_desc_length;
                r_desc_type     <= n_desc_type;
                r_cur_interface <= n_cur_interface;
                r_cur_alternate <= n_cur_alternate;
                r_cur_protocol  <= n_cur_protocol;
                r_best_protocol <= n_best_protocol;
                r_best_iface    <= n_best_iface;
                r_best_alt      <= n_best_alt;
                r_best_ep       <= n_best_ep;
                r_bad           <= n_bad;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_byte <= i_req.data_byte;
            r_in_last <= i_req.last_byte;
        end
        if (finish) begin
            r_out_iface <= n_best_iface;
            r_out_alt   <= n_best_alt;
            r_out_ep    <= n_best_ep;
            r_out_bad   <= n_bad;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.sel_interface = r_out_iface;
    assign o_res.sel_alternate = r_out_alt;
    assign o_res.sel_endpoint  = r_out_ep;
    assign o_res.malformed     = r_out_bad;

`ifndef NO_ASSERTIONS
    a_finish_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> r_out_valid)
        else $error("finished set did not produce a result");

    a_finish_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> (r_byte_offset == '0 && !r_bad && r_best_ep == EP_NONE))
        else $error("parse state not cleared after the last byte");

    a_bad_holds_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bad && !finish) |=> $stable(r_byte_offset) && r_bad)
        else $error("parsing moved after a malformed length");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (r_in_valid && r_in_last && r_out_valid && !o_res.ready))
        else $error("input stalled without a blocked result");
`endif

endmodule
